// ===== rtl/bmr_pkg.sv =====
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared types, codes and constants of the motor reply frame receiver.
// ----------------------------------------------------------------------------
package bmr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PosW     = 7;
  localparam int unsigned CntW     = 3;

  localparam logic [15:0]     CrcInit  = 16'hFFFF;
  localparam logic [15:0]     CrcPoly  = 16'hA001;
  localparam logic [PosW-1:0] PosLimit = 7'd100;

  // header, payload and end byte positions within a frame
  localparam logic [CntW-1:0] PosStart = 3'd0;
  localparam logic [CntW-1:0] PosAddrH = 3'd1;
  localparam logic [CntW-1:0] PosAddrL = 3'd2;
  localparam logic [CntW-1:0] PosKind  = 3'd3;
  localparam logic [CntW-1:0] PosOp    = 3'd4;
  localparam logic [CntW-1:0] PosArg   = 3'd5;
  localparam logic [CntW-1:0] PosEnd7  = 3'd6;
  localparam logic [CntW-1:0] PosEnd8  = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    RegDevAddr  = 3'd0,
    RegStart    = 3'd1,
    RegControl  = 3'd2,
    RegRead     = 3'd3,
    RegStop     = 3'd4,
    RegOpen     = 3'd5,
    RegClose    = 3'd6,
    RegSetPos   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ErrOk     = 2'd0,
    ErrCrc    = 2'd1,
    ErrCtrlOp = 2'd2,
    ErrStatus = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    MotIdle    = 2'd0,
    MotOpening = 2'd1,
    MotClosing = 2'd2
  } motion_e;

  typedef enum logic {
    KindControl = 1'b0,
    KindStatus  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [15:0] dev_addr;
    logic [7:0]  sof_code;
    logic [7:0]  control_code;
    logic [7:0]  read_code;
    logic [7:0]  stop_code;
    logic [7:0]  open_code;
    logic [7:0]  close_code;
    logic [7:0]  set_pos_code;
  } cfg_t;

  typedef struct packed {
    kind_e           frame_kind;
    err_e            error_code;
    motion_e         motion;
    logic [PosW-1:0] position_percent;
    logic            state_published;
    logic            next_request;
  } res_t;

endpackage

// ===== rtl/bmr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bmr_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module bmr_cfg_regs
  import bmr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegDevAddr: cfg_d.dev_addr     = cfg_data_i;
        RegStart:   cfg_d.sof_code     = cfg_data_i[7:0];
        RegControl: cfg_d.control_code = cfg_data_i[7:0];
        RegRead:    cfg_d.read_code    = cfg_data_i[7:0];
        RegStop:    cfg_d.stop_code    = cfg_data_i[7:0];
        RegOpen:    cfg_d.open_code    = cfg_data_i[7:0];
        RegClose:   cfg_d.close_code   = cfg_data_i[7:0];
        RegSetPos:  cfg_d.set_pos_code = cfg_data_i[7:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr     <= 16'h0000;
      cfg_q.sof_code     <= 8'h55;
      cfg_q.control_code <= 8'h03;
      cfg_q.read_code    <= 8'h01;
      cfg_q.stop_code    <= 8'h03;
      cfg_q.open_code    <= 8'h01;
      cfg_q.close_code   <= 8'h02;
      cfg_q.set_pos_code <= 8'h04;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bmr_crc16.sv =====
// ----------------------------------------------------------------------------
// bmr_crc16
// One-byte update of a reflected CRC-16 (polynomial A001).
// ----------------------------------------------------------------------------
module bmr_crc16
  import bmr_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else      c = c >> 1;
    end
    crc_o = c;
  end

endmodule

// ===== rtl/bmr_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// bmr_frame_decoder
// Frame assembly, CRC check and motion / position state for one byte a cycle when stepped.
// ----------------------------------------------------------------------------
module bmr_frame_decoder
  import bmr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_run_q, crc_run_d, crc_snap_q, crc_snap_d, crc_next;
  logic [7:0]      prev_q, prev_d, kind_q, kind_d, op_q, op_d, arg_q, arg_d;
  motion_e         motion_q, motion_d;
  logic [PosW-1:0] pos_q, pos_d, pos_sat;
  logic            expect_q, expect_d;
  logic            push, clear, fin, fin_ctl, crc_ok, is_ctl, hdr_match;
  err_e            err;
  logic            pub;

  bmr_crc16 u_crc (
    .crc_i  (crc_run_q),
    .byte_i (byte_i),
    .crc_o  (crc_next)
  );

  assign crc_ok  = (crc_snap_q[7:0] == prev_q) && (crc_snap_q[15:8] == byte_i);
  assign is_ctl  = (kind_q == cfg_i.control_code);
  assign pos_sat = (arg_q > {1'b0, PosLimit}) ? PosLimit : arg_q[PosW-1:0];

  always_comb begin
    push    = 1'b0;
    clear   = 1'b0;
    fin     = 1'b0;
    fin_ctl = 1'b0;
    hdr_match = 1'b0;
    case (cnt_q)
      PosStart: push = (byte_i == cfg_i.sof_code);
      PosAddrH, PosAddrL, PosKind: begin
        if (cnt_q == PosAddrH)      hdr_match = (byte_i == cfg_i.dev_addr[15:8]);
        else if (cnt_q == PosAddrL) hdr_match = (byte_i == cfg_i.dev_addr[7:0]);
        else hdr_match = (byte_i == cfg_i.control_code) || (byte_i == cfg_i.read_code);
        push  = hdr_match;
        clear = !hdr_match;
      end
      PosEnd7: begin
        push    = 1'b1;
        fin     = is_ctl && (op_q != cfg_i.set_pos_code);
        fin_ctl = 1'b1;
      end
      PosEnd8: begin
        push    = 1'b1;
        fin     = 1'b1;
        fin_ctl = is_ctl;
      end
      default: push = 1'b1;
    endcase
  end

  always_comb begin
    cnt_d      = cnt_q;
    crc_run_d  = crc_run_q;
    crc_snap_d = crc_snap_q;
    prev_d     = prev_q;
    kind_d     = kind_q;
    op_d       = op_q;
    arg_d      = arg_q;
    motion_d   = motion_q;
    pos_d      = pos_q;
    expect_d   = expect_q;
    err        = ErrOk;
    pub        = 1'b0;
    if (step_i && push) begin
      cnt_d      = cnt_q + 1'b1;
      crc_snap_d = crc_run_q;
      crc_run_d  = crc_next;
      prev_d     = byte_i;
      if (cnt_q == PosKind) kind_d = byte_i;
      if (cnt_q == PosOp)   op_d   = byte_i;
      if (cnt_q == PosArg)  arg_d  = byte_i;
    end
    if (step_i && (clear || fin)) begin
      cnt_d      = '0;
      crc_run_d  = CrcInit;
      crc_snap_d = CrcInit;
    end
    if (fin) begin
      if (!crc_ok) begin
        err = ErrCrc;
      end else if (fin_ctl) begin
        pub = 1'b1;
        if (op_q == cfg_i.stop_code)         motion_d = MotIdle;
        else if (op_q == cfg_i.open_code)    motion_d = MotOpening;
        else if (op_q == cfg_i.close_code)   motion_d = MotClosing;
        else if (op_q == cfg_i.set_pos_code) begin
          motion_d = (arg_q > {1'b0, pos_q}) ? MotOpening : MotClosing;
        end else begin
          err = ErrCtrlOp;
          pub = 1'b0;
        end
      end else if (expect_q) begin
        pos_d    = pos_sat;
        pub      = (pos_sat != pos_q);
        expect_d = 1'b0;
      end else if (arg_q <= 8'd2) begin
        motion_d = motion_e'(arg_q[1:0]);
        pub      = (arg_q[1:0] != motion_q);
        expect_d = 1'b1;
      end else begin
        err = ErrStatus;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      crc_run_q  <= CrcInit;
      crc_snap_q <= CrcInit;
      motion_q   <= MotIdle;
      pos_q      <= '0;
      expect_q   <= 1'b0;
    end else if (step_i) begin
      cnt_q      <= cnt_d;
      crc_run_q  <= crc_run_d;
      crc_snap_q <= crc_snap_d;
      motion_q   <= motion_d;
      pos_q      <= pos_d;
      expect_q   <= expect_d;
    end
  end

  // frame bytes are always written earlier in the same frame before use
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      prev_q <= prev_d;
      kind_q <= kind_d;
      op_q   <= op_d;
      arg_q  <= arg_d;
    end
  end

  assign res_valid_o            = step_i && fin;
  assign res_o.frame_kind       = fin_ctl ? KindControl : KindStatus;
  assign res_o.error_code       = err;
  assign res_o.motion           = motion_d;
  assign res_o.position_percent = pos_d;
  assign res_o.state_published  = pub;
  assign res_o.next_request     = expect_d;

endmodule

// ===== rtl/blind_motor_reply_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// blind_motor_reply_frame_receiver_top
// Receives serial reply bytes, assembles and checks frames, reports state.
//
// channel  | dir | handshake                    | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: rx_byte
// m_axis   | out | m_axis_tvalid / m_axis_tready | tuser: frame_kind, tdata: result
// cfg      | in  | cfg_we_i                      | cfg_idx_i, cfg_data_i
//
// one byte per cycle while no held result stalls decode; a byte is decoded
// straight from the input register, and a finished frame's result is then
// offered from the result register.
// the rate is set by the combinational byte crc update and frame decode.
// reset clears the frame counter, crc, motion and position state.
// a held result stalls decode of the next byte; the input register still
// takes one byte while the result waits.
// ----------------------------------------------------------------------------
module blind_motor_reply_frame_receiver_top
  import bmr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [1:0] error_code, [3:2] motion,
                                              // [10:4] position_percent,
                                              // [11] state_published,
                                              // [12] next_request, [15:13] zero
  output logic                m_axis_tuser,   // [0] frame_kind
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       step, dec_valid;
  res_t       dec_res, res_q;
  logic       out_valid_q;

  bmr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_byte_q <= s_axis_tdata;
  end

  bmr_frame_decoder u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (dec_valid),
    .res_o       (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= dec_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_valid) res_q <= dec_res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.frame_kind;
  assign m_axis_tdata  = {3'b000, res_q.next_request, res_q.state_published,
                          res_q.position_percent, res_q.motion, res_q.error_code};

endmodule

// ===== rtl/bmr_checker.sv =====
// ----------------------------------------------------------------------------
// bmr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
module bmr_checker
  import bmr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // position saturates and motion stays a legal code
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:4] <= 7'd100) && (m_axis_tdata[3:2] != 2'd3))
    else $error("position or motion out of range");

  // any error leaves the reported state unpublished
  a_err_pub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ErrOk) |-> !m_axis_tdata[11])
    else $error("error frame published state");

  // a good control reply always publishes
  a_ctl_pub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindControl) && (m_axis_tdata[1:0] == ErrOk)
      |-> m_axis_tdata[11])
    else $error("good control reply not published");

  // status errors only come from status replies, op errors from control replies
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !((m_axis_tdata[1:0] == ErrStatus) && (m_axis_tuser == KindControl))
      && !((m_axis_tdata[1:0] == ErrCtrlOp) && (m_axis_tuser == KindStatus)))
    else $error("error code does not fit frame kind");

endmodule

bind blind_motor_reply_frame_receiver_top bmr_checker u_bmr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/reply_frame_checker.sv =====
// ----------------------------------------------------------------------------
// reply_frame_checker
// Follows the register writes and every accepted byte of the motor reply
// frame receiver, decodes the frames on its own and compares each result
// item, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module reply_frame_checker
  import bmr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [15:0]         m_axis_tdata,   // [1:0] error_code, [3:2] motion,
                                              // [10:4] position_percent,
                                              // [11] state_published,
                                              // [12] next_request, [15:13] zero
  input  logic                m_axis_tuser,   // [0] frame_kind
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatches_o,
  output int                  outstanding_o
);

  cfg_t            regs;
  logic [3:0]      rx_count;
  logic [7:0]      frame_buf [8];
  logic [15:0]     crc_acc;
  logic [15:0]     crc_prev;
  motion_e         motion_now;
  logic [PosW-1:0] pos_now;
  logic            want_pos;
  res_t            reply_q [$];

  function automatic logic [15:0] crc16_add(logic [15:0] crc, logic [7:0] b);
    crc = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    return crc;
  endfunction

  task automatic restart_frame();
    rx_count = 4'd0;
    crc_acc  = CrcInit;
    crc_prev = CrcInit;
  endtask

  task automatic store_byte(logic [7:0] b);
    frame_buf[rx_count[2:0]] = b;
    crc_prev = crc_acc;
    crc_acc  = crc16_add(crc_acc, b);
    rx_count = rx_count + 4'd1;
  endtask

  // end of frame: update motion, position and request order, queue the reply
  task automatic close_frame(logic is_ctl, logic crc_ok);
    res_t            r;
    logic [7:0]      op;
    logic [7:0]      arg;
    logic [PosW-1:0] p;
    op  = frame_buf[PosOp];
    arg = frame_buf[PosArg];
    r.error_code      = ErrOk;
    r.state_published = 1'b0;
    if (!crc_ok) begin
      r.error_code = ErrCrc;
    end else if (is_ctl) begin
      if (op == regs.stop_code) begin
        motion_now = MotIdle;
      end else if (op == regs.open_code) begin
        motion_now = MotOpening;
      end else if (op == regs.close_code) begin
        motion_now = MotClosing;
      end else if (op == regs.set_pos_code) begin
        motion_now = (arg > {1'b0, pos_now}) ? MotOpening : MotClosing;
      end else begin
        r.error_code = ErrCtrlOp;
      end
      r.state_published = (r.error_code == ErrOk);
    end else if (want_pos) begin
      p = (arg > {1'b0, PosLimit}) ? PosLimit : arg[PosW-1:0];
      if (p != pos_now) begin
        pos_now           = p;
        r.state_published = 1'b1;
      end
      want_pos = 1'b0;
    end else if (arg <= 8'd2) begin
      if (motion_now != motion_e'(arg[1:0])) begin
        motion_now        = motion_e'(arg[1:0]);
        r.state_published = 1'b1;
      end
      want_pos = 1'b1;
    end else begin
      r.error_code = ErrStatus;
    end
    restart_frame();
    r.frame_kind       = is_ctl ? KindControl : KindStatus;
    r.motion           = motion_now;
    r.position_percent = pos_now;
    r.next_request     = want_pos;
    reply_q = {reply_q, r};
  endtask

  task automatic take_rx_byte(logic [7:0] b);
    logic [3:0]  k;
    logic [15:0] check;
    logic        crc_ok;
    logic        is_ctl;
    logic        hit;
    k = rx_count;
    if (k == 4'd0) begin
      if (b == regs.sof_code) store_byte(b);
    end else if (k <= 4'd3) begin
      case (k)
        4'd1:    hit = (b == regs.dev_addr[15:8]);
        4'd2:    hit = (b == regs.dev_addr[7:0]);
        default: hit = (b == regs.control_code) || (b == regs.read_code);
      endcase
      if (hit) begin
        store_byte(b);
      end else begin
        restart_frame();
      end
    end else if (k > 4'd7) begin
      restart_frame();
    end else begin
      check = crc_prev;
      store_byte(b);
      crc_ok = (check[7:0] == frame_buf[k[2:0] - 3'd1]) && (check[15:8] == b);
      is_ctl = (frame_buf[PosKind] == regs.control_code);
      if (k == 4'd6) begin
        if (is_ctl && frame_buf[PosOp] != regs.set_pos_code) close_frame(1'b1, crc_ok);
      end else if (k == 4'd7) begin
        close_frame(is_ctl, crc_ok);
      end
    end
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches_o++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  task automatic check_reply();
    res_t want;
    if (reply_q.size() == 0) begin
      mismatches_o++;
      $display("%0t: result item with none expected, expected none actual tuser %0h tdata %0h",
               $time, m_axis_tuser, m_axis_tdata);
    end else begin
      want = reply_q.pop_front();
      check_field("frame_kind", want.frame_kind, m_axis_tuser);
      check_field("error_code", want.error_code, m_axis_tdata[1:0]);
      check_field("motion", want.motion, m_axis_tdata[3:2]);
      check_field("position_percent", want.position_percent, m_axis_tdata[10:4]);
      check_field("state_published", want.state_published, m_axis_tdata[11]);
      check_field("next_request", want.next_request, m_axis_tdata[12]);
      check_field("tdata padding", 0, m_axis_tdata[15:13]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{dev_addr: 16'h0000, sof_code: 8'h55, control_code: 8'h03,
               read_code: 8'h01, stop_code: 8'h03, open_code: 8'h01,
               close_code: 8'h02, set_pos_code: 8'h04};
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;
      restart_frame();
      motion_now = MotIdle;
      pos_now    = '0;
      want_pos   = 1'b0;
      reply_q.delete();
      outstanding_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_reply();
      if (s_axis_tvalid && s_axis_tready) take_rx_byte(s_axis_tdata);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegDevAddr: regs.dev_addr     = cfg_data_i;
          RegStart:   regs.sof_code     = cfg_data_i[7:0];
          RegControl: regs.control_code = cfg_data_i[7:0];
          RegRead:    regs.read_code    = cfg_data_i[7:0];
          RegStop:    regs.stop_code    = cfg_data_i[7:0];
          RegOpen:    regs.open_code    = cfg_data_i[7:0];
          RegClose:   regs.close_code   = cfg_data_i[7:0];
          RegSetPos:  regs.set_pos_code = cfg_data_i[7:0];
          default: ;
        endcase
      end
      outstanding_o <= reply_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives serial reply bytes into the motor reply frame receiver under several
// register settings: a few directed frames, then mostly well-formed frames
// with random content mixed with corrupted, truncated and stray bytes, with
// random idling on both sides, a long result hold-off and a verdict.
// ----------------------------------------------------------------------------
module tb;
  import bmr_pkg::*;

  typedef logic [7:0] frame_t [8];

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'h00;   // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;            // [1:0] error_code, [3:2] motion,
                                                // [10:4] position_percent,
                                                // [11] state_published,
                                                // [12] next_request, [15:13] zero
  logic                m_axis_tuser;            // [0] frame_kind
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  int                  mismatches;
  int                  outstanding;

  cfg_t link_cfg;
  bit   tx_idle_on;
  bit   rx_idle_on;
  bit   rx_hold_req;
  int   tx_count;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  blind_motor_reply_frame_receiver_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  reply_frame_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // result side: random stalls, and one long hold-off when asked
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      m_axis_tready <= !rx_idle_on || ($urandom_range(99) >= 35);
    end
  end

  task automatic send_byte(logic [7:0] b, bit tally);
    while (tx_idle_on && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    if (tally) tx_count++;
  endtask

  task automatic send_frame(frame_t fb, int n);
    for (int i = 0; i < n; i++) send_byte(fb[i], 1'b1);
  endtask

  // lays out a reply under the current settings and appends its crc
  function automatic int build_reply(output frame_t fb, input logic [7:0] kind,
                                     input logic [7:0] op, input logic [7:0] arg);
    logic [15:0] crc;
    int          n;
    fb[PosStart] = link_cfg.sof_code;
    fb[PosAddrH] = link_cfg.dev_addr[15:8];
    fb[PosAddrL] = link_cfg.dev_addr[7:0];
    fb[PosKind]  = kind;
    fb[PosOp]    = op;
    fb[PosArg]   = arg;
    fb[PosEnd7]  = 8'h00;
    fb[PosEnd8]  = 8'h00;
    n = (kind == link_cfg.control_code && op != link_cfg.set_pos_code) ? 5 : 6;
    crc = CrcInit;
    for (int i = 0; i < n; i++) begin
      crc = crc ^ {8'h00, fb[i]};
      for (int j = 0; j < 8; j++) begin
        crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
      end
    end
    fb[n]     = crc[7:0];
    fb[n + 1] = crc[15:8];
    return n + 2;
  endfunction

  task automatic random_traffic(int goal);
    frame_t     fb;
    int         n;
    int         pick;
    int         idx;
    logic [7:0] kind;
    logic [7:0] op;
    logic [7:0] arg;
    while (tx_count < goal) begin
      pick = $urandom_range(99);
      kind = $urandom_range(1) ? link_cfg.control_code : link_cfg.read_code;
      case ($urandom_range(9))
        0, 1:    op = link_cfg.stop_code;
        2, 3:    op = link_cfg.open_code;
        4, 5:    op = link_cfg.close_code;
        6, 7, 8: op = link_cfg.set_pos_code;
        default: op = 8'($urandom);
      endcase
      case ($urandom_range(3))
        0:       arg = 8'($urandom_range(2));
        1:       arg = 8'($urandom_range(3));
        2:       arg = 8'($urandom_range(110, 90));
        default: arg = 8'($urandom);
      endcase
      n = build_reply(fb, kind, op, arg);
      if (pick < 70) begin
        // intact frame
      end else if (pick < 80) begin
        idx = $urandom_range(n - 1, 4);
        fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(7));
      end else if (pick < 86) begin
        idx = $urandom_range(3, 1);
        fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(7));
      end else if (pick < 92) begin
        n = $urandom_range(n - 1, 1);
      end else begin
        n = 0;
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom), 1'b0);
      end
      send_frame(fb, n);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  task automatic load_config(cfg_t c);
    link_cfg = c;
    write_reg(RegDevAddr, c.dev_addr);
    write_reg(RegStart,   {8'($urandom), c.sof_code});
    write_reg(RegControl, {8'($urandom), c.control_code});
    write_reg(RegRead,    {8'($urandom), c.read_code});
    write_reg(RegStop,    {8'($urandom), c.stop_code});
    write_reg(RegOpen,    {8'($urandom), c.open_code});
    write_reg(RegClose,   {8'($urandom), c.close_code});
    write_reg(RegSetPos,  {8'($urandom), c.set_pos_code});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    cfg_t   c;
    frame_t fb;
    int     n;
    c = '{dev_addr: 16'h0000, sof_code: 8'h55, control_code: 8'h03,
          read_code: 8'h01, stop_code: 8'h03, open_code: 8'h01,
          close_code: 8'h02, set_pos_code: 8'h04};
    link_cfg    = c;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    rx_hold_req = 1'b0;
    tx_count    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray byte, status to opening, position above range, set-position downwards
    send_byte(8'h00, 1'b0);
    n = build_reply(fb, link_cfg.read_code, 8'hFF, 8'd1);
    send_frame(fb, n);
    n = build_reply(fb, link_cfg.read_code, 8'h00, 8'd255);
    send_frame(fb, n);
    n = build_reply(fb, link_cfg.control_code, link_cfg.set_pos_code, 8'd0);
    send_frame(fb, n);
    random_traffic(300);
    drain();

    c = '{dev_addr: 16'hFFFF, sof_code: 8'hFF, control_code: 8'h00,
          read_code: 8'hFF, stop_code: 8'h00, open_code: 8'hFF,
          close_code: 8'h80, set_pos_code: 8'h7F};
    load_config(c);
    random_traffic(600);
    drain();

    // kind codes equal, open equal to stop, set-position equal to close
    c = '{dev_addr: 16'h0000, sof_code: 8'h00, control_code: 8'h5A,
          read_code: 8'h5A, stop_code: 8'h10, open_code: 8'h10,
          close_code: 8'h20, set_pos_code: 8'h20};
    load_config(c);
    random_traffic(850);
    drain();

    c.dev_addr     = 16'($urandom);
    c.sof_code     = 8'($urandom);
    c.control_code = 8'($urandom);
    c.read_code    = 8'($urandom);
    c.stop_code    = 8'($urandom);
    c.open_code    = 8'($urandom);
    c.close_code   = 8'($urandom);
    c.set_pos_code = 8'($urandom);
    load_config(c);
    random_traffic(1100);
    drain();

    c = '{dev_addr: 16'($urandom), sof_code: 8'h55, control_code: 8'h03,
          read_code: 8'h01, stop_code: 8'h03, open_code: 8'h01,
          close_code: 8'h02, set_pos_code: 8'h04};
    load_config(c);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_traffic(1250);
    rx_hold_req = 1'b1;
    random_traffic(1350);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    random_traffic(1550);
    drain();

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
